@@ rtl/core/poac_pkg.sv @@
// Shared constants, types and tree-index helpers for the Path ORAM access controller.
package poac_pkg;

	localparam int BLOCK_COUNT  = 1024;
	localparam int BUCKET_SLOTS = 4;
	localparam int STASH_DEPTH  = 64;
	localparam int PAYLOAD_BITS = 64;

	localparam int BLK_W   = 10;
	localparam int DATA_W  = 64;
	localparam int PAY_W   = PAYLOAD_BITS;
	localparam int LEAF_W  = $clog2(BLOCK_COUNT);
	localparam int LEVELS  = LEAF_W + 1;
	localparam int BUCKET_COUNT = (1 << LEVELS) - 1;
	localparam int BKT_W   = LEVELS;
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int SLOT_W  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
	localparam int FILL_W  = $clog2(BUCKET_SLOTS + 1);
	localparam int SIDX_W  = $clog2(STASH_DEPTH);
	localparam int CNT_W   = $clog2(STASH_DEPTH + 1);
	localparam int NUM_CLR = (BUCKET_COUNT > BLOCK_COUNT) ? BUCKET_COUNT : BLOCK_COUNT;
	localparam int CLR_W   = $clog2(NUM_CLR);

	typedef struct packed {
		logic              valid;
		logic [BLK_W-1:0]  tag;
		logic [LEAF_W-1:0] leaf;
		logic [PAY_W-1:0]  payload;
	} slot_t;

	typedef slot_t [BUCKET_SLOTS-1:0] row_t;

	typedef struct packed {
		logic              clr_en;
		logic [CLR_W-1:0]  clr_addr;
		logic              req_load;
		logic              pos_wr;
		logic              tree_rd;
		logic [LVL_W-1:0]  lvl;
		logic              push_slot;
		logic [SLOT_W-1:0] slot;
		logic              stash_rd;
		logic [SIDX_W-1:0] idx;
		logic              scan_chk;
		logic              miss_push;
		logic              ev_begin;
		logic              ev_chk;
		logic              ev_wr;
		logic              out_load;
	} cmd_t;

	typedef struct packed {
		logic             oob;
		logic             hit;
		logic [CNT_W-1:0] cnt;
		logic             ovf;
	} sts_t;

	// bucket on the path to leaf at level lvl: (2^lvl - 1) + (leaf >> (LEVELS-1-lvl))
	function automatic logic [BKT_W-1:0] bucket_at(input logic [LEAF_W-1:0] leaf,
			input logic [LVL_W-1:0] lvl);
		logic [BKT_W-1:0] base;
		logic [BKT_W-1:0] off;
		base = (BKT_W'(1) << lvl) - BKT_W'(1);
		off  = BKT_W'(leaf) >> (LVL_W'(LEAF_W) - lvl);
		return base + off;
	endfunction

	function automatic logic path_match(input logic [LEAF_W-1:0] a,
			input logic [LEAF_W-1:0] b, input logic [LVL_W-1:0] lvl);
		logic [LVL_W-1:0] sh;
		sh = LVL_W'(LEAF_W) - lvl;
		return (a >> sh) == (b >> sh);
	endfunction

endpackage

@@ rtl/core/poac_ctrl.sv @@
// Sequencer: reset clear sweep, path read, stash scan, per-level eviction, result hand-off.
module poac_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output poac_pkg::cmd_t cmd,
	input  poac_pkg::sts_t sts
);
	import poac_pkg::*;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_POS  = 4'd2;
	localparam logic [3:0] S_PRD  = 4'd3;
	localparam logic [3:0] S_PUSH = 4'd4;
	localparam logic [3:0] S_SRD  = 4'd5;
	localparam logic [3:0] S_SCHK = 4'd6;
	localparam logic [3:0] S_MISS = 4'd7;
	localparam logic [3:0] S_EBEG = 4'd8;
	localparam logic [3:0] S_ERD  = 4'd9;
	localparam logic [3:0] S_ECHK = 4'd10;
	localparam logic [3:0] S_EWR  = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0]        state_q, state_d;
	logic [CLR_W-1:0]  clr_q;
	logic [LVL_W-1:0]  lvl_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  idx_q;
	logic              out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd          = '0;
		cmd.clr_addr = clr_q;
		cmd.lvl      = lvl_q;
		cmd.slot     = slot_q;
		cmd.idx      = idx_q[SIDX_W-1:0];
		state_d      = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_en = 1'b1;
				if (clr_q == CLR_W'(NUM_CLR - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_d = S_POS;
				end
			end
			S_POS: begin
				if (sts.oob) begin
					state_d = S_DONE;
				end else begin
					cmd.pos_wr = 1'b1;
					state_d = S_PRD;
				end
			end
			S_PRD: begin
				cmd.tree_rd = 1'b1;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				cmd.push_slot = 1'b1;
				if (slot_q == SLOT_W'(BUCKET_SLOTS - 1))
					state_d = (lvl_q == LVL_W'(LEVELS - 1)) ? S_SRD : S_PRD;
			end
			S_SRD: begin
				if (idx_q == sts.cnt) begin
					state_d = S_MISS;
				end else begin
					cmd.stash_rd = 1'b1;
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				cmd.scan_chk = 1'b1;
				state_d = sts.hit ? S_EBEG : S_SRD;
			end
			S_MISS: begin
				cmd.miss_push = 1'b1;
				state_d = S_EBEG;
			end
			S_EBEG: begin
				cmd.ev_begin = 1'b1;
				state_d = S_ERD;
			end
			S_ERD: begin
				if (idx_q == sts.cnt) begin
					state_d = S_EWR;
				end else begin
					cmd.stash_rd = 1'b1;
					state_d = S_ECHK;
				end
			end
			S_ECHK: begin
				cmd.ev_chk = 1'b1;
				state_d = S_ERD;
			end
			S_EWR: begin
				cmd.ev_wr = 1'b1;
				state_d = (lvl_q == '0) ? S_DONE : S_EBEG;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			lvl_q     <= '0;
			slot_q    <= '0;
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR)
				clr_q <= clr_q + CLR_W'(1);
			case (state_q)
				S_POS: lvl_q <= '0;
				S_PRD: slot_q <= '0;
				S_PUSH: begin
					slot_q <= slot_q + SLOT_W'(1);
					if (slot_q == SLOT_W'(BUCKET_SLOTS - 1)) begin
						if (lvl_q == LVL_W'(LEVELS - 1)) begin
							idx_q <= '0;
							lvl_q <= LVL_W'(LEVELS - 1);
						end else begin
							lvl_q <= lvl_q + LVL_W'(1);
						end
					end
				end
				S_SCHK: idx_q <= idx_q + CNT_W'(1);
				S_EBEG: idx_q <= '0;
				S_ECHK: idx_q <= idx_q + CNT_W'(1);
				S_EWR: lvl_q <= lvl_q - LVL_W'(1);
				default: ;
			endcase
			if (cmd.out_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

endmodule

@@ rtl/core/poac_dpath.sv @@
// Datapath: position map, bucket tree and stash memories, request and result registers.
module poac_dpath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  poac_pkg::cmd_t                  cmd,
	output poac_pkg::sts_t                  sts,
	input  logic                            op,
	input  logic [poac_pkg::BLK_W-1:0]      block_index,
	input  logic [9:0]                      new_leaf,
	input  logic [poac_pkg::DATA_W-1:0]     write_data,
	output logic [poac_pkg::DATA_W-1:0]     read_data,
	output logic                            found,
	output logic                            stash_overflow
);
	import poac_pkg::*;

	logic [LEAF_W-1:0] pos_mem [BLOCK_COUNT];
	row_t              tree_mem [BUCKET_COUNT];
	slot_t             stash_mem [STASH_DEPTH];

	logic [LEAF_W-1:0] pos_rd_q;
	row_t              tree_rd_q;
	slot_t             stash_rd_q;
	row_t              build_q;

	logic              op_q;
	logic [BLK_W-1:0]  blk_q;
	logic [LEAF_W-1:0] nleaf_q;
	logic [PAY_W-1:0]  wdata_q;
	logic [LEAF_W-1:0] old_leaf_q;
	logic [PAY_W-1:0]  rdata_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  keep_q;
	logic [FILL_W-1:0] filled_q;
	logic              ovf_q;
	logic              found_q;

	logic [BKT_W-1:0]  bkt;
	logic              hit;
	logic              take;
	logic              push_req;
	slot_t             push_word;
	logic              st_we;
	logic [SIDX_W-1:0] st_wa;
	slot_t             st_wd;

	assign bkt  = bucket_at(old_leaf_q, cmd.lvl);
	assign hit  = (stash_rd_q.tag == blk_q);
	assign take = (filled_q < FILL_W'(BUCKET_SLOTS))
		&& path_match(stash_rd_q.leaf, old_leaf_q, cmd.lvl);

	assign sts.oob = (int'(blk_q) >= BLOCK_COUNT);
	assign sts.hit = hit;
	assign sts.cnt = cnt_q;
	assign sts.ovf = ovf_q;

	// one stash write port shared by path pushes, miss append, target update and compaction
	always_comb begin
		push_req  = 1'b0;
		push_word = tree_rd_q[cmd.slot];
		if (cmd.push_slot) begin
			push_req = tree_rd_q[cmd.slot].valid;
		end else if (cmd.miss_push) begin
			push_req  = op_q;
			push_word = '{valid: 1'b1, tag: blk_q, leaf: nleaf_q, payload: wdata_q};
		end
		st_we = 1'b0;
		st_wa = cnt_q[SIDX_W-1:0];
		st_wd = push_word;
		if (push_req && cnt_q < CNT_W'(STASH_DEPTH)) begin
			st_we = 1'b1;
		end else if (cmd.scan_chk && hit) begin
			st_we = 1'b1;
			st_wa = cmd.idx;
			st_wd = '{valid: 1'b1, tag: blk_q, leaf: nleaf_q,
				payload: op_q ? wdata_q : stash_rd_q.payload};
		end else if (cmd.ev_chk && !take) begin
			st_we = 1'b1;
			st_wa = keep_q[SIDX_W-1:0];
			st_wd = stash_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en && int'(cmd.clr_addr) < BLOCK_COUNT)
			pos_mem[LEAF_W'(cmd.clr_addr)] <= '0;
		else if (cmd.pos_wr)
			pos_mem[LEAF_W'(blk_q)] <= nleaf_q;
		if (cmd.req_load)
			pos_rd_q <= pos_mem[LEAF_W'(block_index)];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en && int'(cmd.clr_addr) < BUCKET_COUNT)
			tree_mem[BKT_W'(cmd.clr_addr)] <= '0;
		else if (cmd.ev_wr)
			tree_mem[bkt] <= build_q;
		if (cmd.tree_rd)
			tree_rd_q <= tree_mem[bkt];
	end

	always_ff @(posedge clk) begin
		if (st_we)
			stash_mem[st_wa] <= st_wd;
		if (cmd.stash_rd)
			stash_rd_q <= stash_mem[cmd.idx];
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			op_q    <= op;
			blk_q   <= block_index;
			nleaf_q <= LEAF_W'(new_leaf);
			wdata_q <= PAY_W'(write_data);
		end
		if (cmd.pos_wr)
			old_leaf_q <= pos_rd_q;
		if (cmd.ev_begin) begin
			for (int i = 0; i < BUCKET_SLOTS; i++)
				build_q[i].valid <= 1'b0;
		end else if (cmd.ev_chk && take) begin
			build_q[filled_q[SLOT_W-1:0]] <= stash_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q          <= '0;
			keep_q         <= '0;
			filled_q       <= '0;
			ovf_q          <= 1'b0;
			found_q        <= 1'b0;
			rdata_q        <= '0;
			read_data      <= '0;
			found          <= 1'b0;
			stash_overflow <= 1'b0;
		end else begin
			if (push_req) begin
				if (cnt_q < CNT_W'(STASH_DEPTH))
					cnt_q <= cnt_q + CNT_W'(1);
				else
					ovf_q <= 1'b1;
			end
			if (cmd.req_load) begin
				found_q <= 1'b0;
				rdata_q <= '0;
			end
			if (cmd.scan_chk && hit) begin
				found_q <= 1'b1;
				if (!op_q)
					rdata_q <= stash_rd_q.payload;
			end
			if (cmd.ev_begin) begin
				keep_q   <= '0;
				filled_q <= '0;
			end
			if (cmd.ev_chk) begin
				if (take)
					filled_q <= filled_q + FILL_W'(1);
				else
					keep_q <= keep_q + CNT_W'(1);
			end
			if (cmd.ev_wr)
				cnt_q <= keep_q;
			if (cmd.out_load) begin
				read_data      <= DATA_W'(rdata_q);
				found          <= found_q;
				stash_overflow <= ovf_q;
			end
		end
	end

endmodule

@@ rtl/core/path_oram_access_controller.sv @@
// Path ORAM access controller top level: sequencer, datapath and checks.
// After reset the block sweeps the bucket tree and position map, one row per cycle, over
// all BUCKET_COUNT (2047) rows with in_stall high. An access then reads every bucket on
// the old path into the stash, scans the stash up to the target (a miss scans all of it
// and, on a write, appends the block), then evicts level by level, deepest bucket first.
// The eviction pass, which checks every stash word (up to 64) at each tree level through
// the one stash write port, dominates the access time. A finished result waits in the
// output register while the next word is taken in.
module path_oram_access_controller (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        op,
	input  logic [poac_pkg::BLK_W-1:0]  block_index,
	input  logic [9:0]                  new_leaf,
	input  logic [poac_pkg::DATA_W-1:0] write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [poac_pkg::DATA_W-1:0] read_data,
	output logic                        found,
	output logic                        stash_overflow
);
	import poac_pkg::*;

	cmd_t cmd;
	sts_t sts;

	poac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	poac_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.block_index    (block_index),
		.new_leaf       (new_leaf),
		.write_data     (write_data),
		.read_data      (read_data),
		.found          (found),
		.stash_overflow (stash_overflow)
	);

	a_stash_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.cnt <= CNT_W'(STASH_DEPTH))
		else $error("stash count beyond depth");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sts.ovf |=> sts.ovf)
		else $error("overflow flag cleared");

	a_stash_port: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.push_slot, cmd.miss_push, cmd.scan_chk, cmd.ev_chk, cmd.ev_wr,
			cmd.clr_en}))
		else $error("stash commands overlap");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || !out_stall))
		else $error("result overwritten while stalled");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for path_oram_access_controller: directed and random traffic against a path ORAM predictor.
module testbench;
	import poac_pkg::*;

	typedef enum bit {OP_READ = 1'b0, OP_WRITE = 1'b1} access_op_t;

	localparam int TREE_SLOTS = BUCKET_COUNT * BUCKET_SLOTS;

	typedef struct {
		access_op_t       kind;
		logic [BLK_W-1:0] blk;
		logic [9:0]       leaf;
		logic [63:0]      wdata;
		bit               drain_first;
	} access_t;

	typedef struct {
		logic [63:0] rdata;
		logic        hit;
		logic        ovf;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [BLK_W-1:0] block_index;
	logic [9:0]  new_leaf;
	logic [63:0] write_data;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] read_data;
	logic        found;
	logic        stash_overflow;

	path_oram_access_controller dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .block_index(block_index), .new_leaf(new_leaf), .write_data(write_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_data(read_data), .found(found), .stash_overflow(stash_overflow)
	);

	access_t pending_access[$];
	reply_t  expected_reply[$];
	int      error_count = 0;
	int      hits_seen = 0, writes_sent = 0, replies_seen = 0;

	// predictor state
	int          leaf_of[BLOCK_COUNT];
	bit          slot_used[TREE_SLOTS];
	int          slot_blk[TREE_SLOTS];
	logic [63:0] slot_data[TREE_SLOTS];
	int          stash_blk[$];
	logic [63:0] stash_data[$];
	bit          overflow_flag;

	function automatic int bucket_on_path(int leaf, int lv);
		return ((1 << lv) - 1) + (leaf >> (LEVELS - 1 - lv));
	endfunction

	function automatic void stash_add(int blk, logic [63:0] data);
		if (stash_blk.size() >= STASH_DEPTH)
			overflow_flag = 1;
		else begin
			stash_blk.insert(stash_blk.size(), blk);
			stash_data.insert(stash_data.size(), data);
		end
	endfunction

	function automatic void oram_access(access_t a);
		reply_t r;
		int old_leaf, blk, hit_at, base, bkt, filled, tl;
		int keep_blk[$];
		logic [63:0] keep_data[$];
		logic [63:0] wd;
		blk = int'(a.blk);
		wd = a.wdata;
		r.rdata = '0;
		hit_at = -1;
		old_leaf = leaf_of[blk];
		leaf_of[blk] = int'(a.leaf) & ((1 << LEAF_W) - 1);
		for (int lv = 0; lv < LEVELS; lv++) begin
			base = bucket_on_path(old_leaf, lv) * BUCKET_SLOTS;
			for (int j = 0; j < BUCKET_SLOTS; j++)
				if (slot_used[base + j]) begin
					stash_add(slot_blk[base + j], slot_data[base + j]);
					slot_used[base + j] = 0;
				end
		end
		foreach (stash_blk[k])
			if (hit_at < 0 && stash_blk[k] == blk) hit_at = k;
		r.hit = hit_at >= 0;
		if (a.kind == OP_WRITE) begin
			if (r.hit) stash_data[hit_at] = wd;
			else stash_add(blk, wd);
		end else if (r.hit)
			r.rdata = stash_data[hit_at];
		// greedy eviction, deepest bucket first
		for (int lv = LEVELS - 1; lv >= 0; lv--) begin
			bkt = bucket_on_path(old_leaf, lv);
			base = bkt * BUCKET_SLOTS;
			filled = 0;
			keep_blk.delete();
			keep_data.delete();
			foreach (stash_blk[k]) begin
				tl = leaf_of[stash_blk[k]];
				if (filled < BUCKET_SLOTS && bucket_on_path(tl, lv) == bkt) begin
					slot_used[base + filled] = 1;
					slot_blk[base + filled] = stash_blk[k];
					slot_data[base + filled] = stash_data[k];
					filled++;
				end else begin
					keep_blk.insert(keep_blk.size(), stash_blk[k]);
					keep_data.insert(keep_data.size(), stash_data[k]);
				end
			end
			stash_blk = keep_blk;
			stash_data = keep_data;
			for (int j = filled; j < BUCKET_SLOTS; j++) slot_used[base + j] = 0;
		end
		r.ovf = overflow_flag;
		expected_reply.insert(expected_reply.size(), r);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 15);
		return $urandom_range(30, 90);
	endfunction

	function automatic void queue_access(access_op_t kind, int blk, int leaf,
			logic [63:0] wdata, bit drain);
		access_t a;
		a.kind = kind;
		a.blk = BLK_W'(blk);
		a.leaf = 10'(leaf);
		a.wdata = wdata;
		a.drain_first = drain;
		pending_access.insert(pending_access.size(), a);
	endfunction

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		access_t a;
		bit fire;
		if (!arst_n) begin
			in_valid <= 0;
			op <= 0;
			block_index <= '0;
			new_leaf <= '0;
			write_data <= '0;
		end else begin
			fire = in_valid && !in_stall;
			if (fire) begin
				a.kind = access_op_t'(op);
				a.blk = block_index;
				a.leaf = new_leaf;
				a.wdata = write_data;
				oram_access(a);
			end
			if (!in_valid || fire) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 0;
				end else if (pending_access.size() > 0 &&
						!(pending_access[0].drain_first && expected_reply.size() > 0)) begin
					a = pending_access.pop_front();
					in_valid <= 1;
					op <= a.kind;
					block_index <= a.blk;
					new_leaf <= a.leaf;
					write_data <= a.wdata;
					if (a.kind == OP_WRITE) writes_sent++;
					send_gap = pick_gap();
				end else
					in_valid <= 0;
			end
		end
	end

	// monitor
	int hold_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		reply_t e;
		if (!arst_n)
			out_stall <= 0;
		else begin
			if (out_valid && !out_stall) begin
				replies_seen++;
				if (expected_reply.size() == 0) begin
					$display("%0t: unexpected word read_data=%h found=%b ovf=%b",
						$time, read_data, found, stash_overflow);
					error_count++;
				end else begin
					e = expected_reply.pop_front();
					if (e.hit) hits_seen++;
					if (read_data !== e.rdata) begin
						$display("%0t: read_data expected %h actual %h", $time, e.rdata, read_data);
						error_count++;
					end
					if (found !== e.hit) begin
						$display("%0t: found expected %b actual %b", $time, e.hit, found);
						error_count++;
					end
					if (stash_overflow !== e.ovf) begin
						$display("%0t: stash_overflow expected %b actual %b",
							$time, e.ovf, stash_overflow);
						error_count++;
					end
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1;
			end else begin
				hold_cnt = pick_gap();
				out_stall <= hold_cnt > 0;
			end
		end
	end

	initial begin
		int blk;
		overflow_flag = 0;
		foreach (leaf_of[i]) leaf_of[i] = 0;
		foreach (slot_used[i]) slot_used[i] = 0;
		// directed: never-written reads, field extremes, read-back
		queue_access(OP_READ, 0, 0, '1, 0);
		queue_access(OP_READ, 1023, 1023, '0, 0);
		queue_access(OP_WRITE, 0, 1023, '1, 0);
		queue_access(OP_WRITE, 1023, 0, 64'h0, 0);
		queue_access(OP_READ, 0, 0, '0, 0);
		queue_access(OP_READ, 1023, 1023, '1, 0);
		queue_access(OP_WRITE, 1023, 512, 64'hA5A5_5A5A_F0F0_0F0F, 0);
		queue_access(OP_WRITE, 1023, 511, 64'h5A5A_A5A5_0F0F_F0F0, 0);
		queue_access(OP_READ, 1023, 1, '0, 0);
		queue_access(OP_WRITE, 512, 341, 64'h8000_0000_0000_0001, 0);
		queue_access(OP_READ, 512, 682, '0, 0);
		queue_access(OP_READ, 0, 1023, '0, 0);
		for (int i = 1; i <= 8; i++)
			queue_access(OP_WRITE, i, 1023, {$urandom, $urandom}, 0);
		for (int i = 1; i <= 8; i++)
			queue_access(OP_READ, i, $urandom_range(0, 1023), '0, 0);
		// random traffic over a small working set so reads hit
		for (int i = 0; i < 290; i++) begin
			blk = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 47) : $urandom_range(0, 1023);
			queue_access(access_op_t'($urandom_range(0, 1)), blk, $urandom_range(0, 1023),
				{$urandom, $urandom}, i == 150);
		end
		// pile many blocks onto leaf 0 until the stash overflows
		for (int i = 0; i < 110; i++)
			queue_access(OP_WRITE, 900 + i, 0, {$urandom, $urandom}, i == 0);
		for (int i = 0; i < 12; i++)
			queue_access(OP_READ, 900 + $urandom_range(0, 109), $urandom_range(0, 1023), '0, 0);

		wait (arst_n);
		while (pending_access.size() > 0 || in_valid || expected_reply.size() > 0)
			@(posedge clk);
		repeat (2000) @(posedge clk);
		$display("covered %0d accesses (%0d writes), %0d hits, overflow flag %b",
			replies_seen, writes_sent, hits_seen, overflow_flag);
		if (error_count == 0)
			$display("path_oram_access_controller: match");
		else
			$display("path_oram_access_controller: mismatch");
		$finish;
	end

	initial begin
		#8000000;
		$display("timeout with %0d words outstanding", expected_reply.size());
		$display("path_oram_access_controller: mismatch");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/poac_pkg.sv
rtl/core/poac_ctrl.sv
rtl/core/poac_dpath.sv
rtl/core/path_oram_access_controller.sv
sim/testbench.sv
